// ----- rtl/polygon_node_transform_core_macros.svh -----
// Assertion macros for the polygon node transform core.
// Depends on nothing; included by the files that carry assertions.
`ifndef POLYGON_NODE_TRANSFORM_CORE_MACROS_SVH
`define POLYGON_NODE_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PNT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PNT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pnt_pkg.sv -----
// Shared types and constants of the polygon node transform core.
// Depends on nothing; imported by every module of the block.
package pnt_pkg;

  localparam int MAX_NODES = 65536;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int IDX_W     = 16;
  localparam int COEFF_W   = 24;
  localparam int COORD_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [COEFF_W-1:0] COEFF_PERP_RESET       = COEFF_W'(0);
  localparam logic [COEFF_W-1:0] COEFF_NEIGHBOURS_RESET = COEFF_W'(16384);
  localparam logic [COEFF_W-1:0] COEFF_SELF_RESET       = COEFF_W'(32768);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEFF_PERP       = 2'd0,
    REG_COEFF_NEIGHBOURS = 2'd1,
    REG_COEFF_SELF       = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] node_x;
    logic [COORD_W-1:0] node_y;
    logic               last_node;
  } in_beat_t;

  typedef struct packed {
    logic [COORD_W-1:0] new_x;
    logic [COORD_W-1:0] new_y;
    logic [IDX_W-1:0]   node_index;
    logic               last_result;
    logic               bad_polygon;
  } out_beat_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } node_t;

  typedef struct packed {
    logic [COEFF_W-1:0] perp;
    logic [COEFF_W-1:0] neighbours;
    logic [COEFF_W-1:0] self_w;
  } coeff_t;

  // One result to compute: predecessor, node and successor plus tags.
  typedef struct packed {
    logic             valid;
    node_t            p;
    node_t            c;
    node_t            s;
    logic [IDX_W-1:0] index;
    logic             last_result;
    logic             bad_polygon;
  } job_t;

  typedef struct packed {
    logic             tail_busy;
    logic [CNT_W-1:0] node_count;
  } seq_status_t;

endpackage

// ----- rtl/pnt_sequencer.sv -----
// Node history and result sequencing of the polygon node transform core.
// Depends on pnt_pkg.
module pnt_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pnt_pkg::in_beat_t    in_data,
  output pnt_pkg::job_t        job,
  input  logic                 job_ready,
  output pnt_pkg::seq_status_t status
);
  import pnt_pkg::*;

  typedef enum logic [1:0] {
    TAIL_IDLE,
    TAIL_PREV,
    TAIL_FIRST
  } tail_state_t;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NODES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  tail_state_t      tail_state;
  node_t            first_node;
  node_t            second_node;
  node_t            older_node;
  node_t            newer_node;
  logic [CNT_W-1:0] node_count;
  logic [IDX_W-1:0] tail_index;

  node_t            cur;
  logic             accept;
  logic             in_window;
  logic [IDX_W-1:0] prev_index;

  assign cur.x      = in_data.node_x;
  assign cur.y      = in_data.node_y;
  assign in_ready   = job_ready && (tail_state == TAIL_IDLE);
  assign accept     = in_valid && in_ready;
  assign in_window  = (node_count >= CNT_TWO) && (node_count < CNT_MAX);
  assign prev_index = IDX_W'(node_count - CNT_ONE);

  assign status.tail_busy  = (tail_state != TAIL_IDLE);
  assign status.node_count = node_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_state  <= TAIL_IDLE;
      job.valid   <= 1'b0;
      node_count  <= '0;
      first_node  <= '0;
      second_node <= '0;
      older_node  <= '0;
      newer_node  <= '0;
    end else if (accept) begin
      older_node <= newer_node;
      newer_node <= cur;
      job.p      <= older_node;
      job.c      <= newer_node;
      job.s      <= cur;
      job.index  <= prev_index;
      if (!in_data.last_node) begin
        job.valid       <= in_window;
        job.last_result <= 1'b0;
        job.bad_polygon <= 1'b0;
        if (node_count == '0) begin
          first_node <= cur;
        end
        if (node_count == CNT_ONE) begin
          second_node <= cur;
        end
        if (node_count < CNT_MAX) begin
          node_count <= node_count + CNT_ONE;
        end
      end else begin
        node_count <= '0;
        job.valid  <= 1'b1;
        if (in_window) begin
          // Valid polygon: the two closing results follow from the tail.
          job.last_result <= 1'b0;
          job.bad_polygon <= 1'b0;
          tail_index      <= IDX_W'(node_count);
          tail_state      <= TAIL_PREV;
        end else begin
          job.index       <= '0;
          job.last_result <= 1'b1;
          job.bad_polygon <= 1'b1;
        end
      end
    end else if (job_ready) begin
      unique case (tail_state)
        TAIL_PREV: begin
          job.valid       <= 1'b1;
          job.p           <= older_node;
          job.c           <= newer_node;
          job.s           <= first_node;
          job.index       <= tail_index;
          job.last_result <= 1'b0;
          job.bad_polygon <= 1'b0;
          tail_state      <= TAIL_FIRST;
        end
        TAIL_FIRST: begin
          job.valid       <= 1'b1;
          job.p           <= newer_node;
          job.c           <= first_node;
          job.s           <= second_node;
          job.index       <= '0;
          job.last_result <= 1'b1;
          job.bad_polygon <= 1'b0;
          tail_state      <= TAIL_IDLE;
        end
        default: begin
          job.valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/pnt_datapath.sv -----
// Three-stage arithmetic pipeline: neighbour sums, products, rounding.
// Depends on pnt_pkg.
module pnt_datapath (
  input  logic               clk,
  input  logic               rst,
  input  pnt_pkg::coeff_t    coeff,
  input  pnt_pkg::job_t      job,
  output logic               job_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output pnt_pkg::out_beat_t out_data
);
  import pnt_pkg::*;

  localparam int SUM_W  = COORD_W + 1;
  localparam int PROD_W = COEFF_W + SUM_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RND_W  = ACC_W - 16;

  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(64'sd2147483647);
  localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-64'sd2147483648);

  function automatic logic [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [RND_W-1:0] r;
    t = acc + ACC_W'(32768);
    r = t[ACC_W-1:16];
    if (r > SAT_HI) begin
      return COORD_W'(SAT_HI);
    end else if (r < SAT_LO) begin
      return COORD_W'(SAT_LO);
    end
    return r[COORD_W-1:0];
  endfunction

  // Stage A: differences and sums of the neighbours.
  logic                      a_valid;
  logic signed [SUM_W-1:0]   a_dyx, a_sx, a_dxy, a_sy;
  logic signed [COORD_W-1:0] a_cx, a_cy;
  logic [IDX_W-1:0]          a_index;
  logic                      a_last, a_bad;

  // Stage B: the six products.
  logic                      b_valid;
  logic signed [PROD_W-1:0]  b_px0, b_px1, b_px2, b_py0, b_py1, b_py2;
  logic [IDX_W-1:0]          b_index;
  logic                      b_last, b_bad;

  logic a_adv, b_adv, c_adv;

  assign c_adv     = !out_valid || out_ready;
  assign b_adv     = !b_valid || c_adv;
  assign a_adv     = !a_valid || b_adv;
  assign job_ready = a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_adv) begin
      a_valid <= job.valid;
    end
    if (a_adv) begin
      a_dyx   <= {job.s.y[COORD_W-1], job.s.y} - {job.p.y[COORD_W-1], job.p.y};
      a_sx    <= {job.p.x[COORD_W-1], job.p.x} + {job.s.x[COORD_W-1], job.s.x};
      a_dxy   <= {job.p.x[COORD_W-1], job.p.x} - {job.s.x[COORD_W-1], job.s.x};
      a_sy    <= {job.p.y[COORD_W-1], job.p.y} + {job.s.y[COORD_W-1], job.s.y};
      a_cx    <= job.c.x;
      a_cy    <= job.c.y;
      a_index <= job.index;
      a_last  <= job.last_result;
      a_bad   <= job.bad_polygon;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_adv) begin
      b_valid <= a_valid;
    end
    if (b_adv) begin
      b_px0   <= $signed(coeff.perp) * a_dyx;
      b_px1   <= $signed(coeff.neighbours) * a_sx;
      b_px2   <= $signed(coeff.self_w) * a_cx;
      b_py0   <= $signed(coeff.perp) * a_dxy;
      b_py1   <= $signed(coeff.neighbours) * a_sy;
      b_py2   <= $signed(coeff.self_w) * a_cy;
      b_index <= a_index;
      b_last  <= a_last;
      b_bad   <= a_bad;
    end
  end

  logic signed [ACC_W-1:0] acc_x, acc_y;

  assign acc_x = ACC_W'(b_px0) + ACC_W'(b_px1) + ACC_W'(b_px2);
  assign acc_y = ACC_W'(b_py0) + ACC_W'(b_py1) + ACC_W'(b_py2);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_adv) begin
      out_valid <= b_valid;
    end
    if (c_adv) begin
      // The error result carries zero coordinates and index.
      out_data.new_x       <= b_bad ? '0 : round_sat(acc_x);
      out_data.new_y       <= b_bad ? '0 : round_sat(acc_y);
      out_data.node_index  <= b_index;
      out_data.last_result <= b_last;
      out_data.bad_polygon <= b_bad;
    end
  end

endmodule

// ----- rtl/polygon_node_transform_core.sv -----
// Top level of the polygon node transform core: coefficient registers,
// sequencer and arithmetic pipeline. Depends on pnt_pkg, pnt_sequencer,
// pnt_datapath and the assertion macro header.
//
// Usage. Nodes of one closed polygon arrive in order on the input channel
// (in_valid / in_ready / in_data), one beat per node, the final node flagged
// by last_node. Results leave on the output channel (out_valid / out_ready /
// out_data), each tagged with its node index. The result for node k is
// started when node k+1 is taken; the final node starts three results (nodes
// n-2, n-1 and 0, the last flagged last_result). A polygon with fewer than
// three nodes or more than MAX_NODES nodes closes with one error beat instead.
// Throughput is one node per cycle while the output does not stall; after a
// final node the input is held off while the sequencer issues the two
// closing results. Each result passes from the job register through the sum
// stage and the product stage to the output register. A stalled receiver
// backs the pipeline up stage by stage, and in_ready falls once every stage
// holds a result. Reset clears the node history, the node count and all
// valid flags, and loads the coefficient defaults. Coefficients are written
// through cfg_write / cfg_index / cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce.
`include "polygon_node_transform_core_macros.svh"

module polygon_node_transform_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pnt_pkg::in_beat_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pnt_pkg::out_beat_t              out_data,
  input  logic                            cfg_write,
  input  logic [pnt_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [pnt_pkg::COEFF_W-1:0]     cfg_data
);
  import pnt_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NODES);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  coeff_t      coeff;
  job_t        job;
  logic        job_ready;
  seq_status_t status;

  // Coefficient registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff.perp       <= COEFF_PERP_RESET;
      coeff.neighbours <= COEFF_NEIGHBOURS_RESET;
      coeff.self_w     <= COEFF_SELF_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_e'(cfg_index))
        REG_COEFF_PERP:       coeff.perp       <= cfg_data;
        REG_COEFF_NEIGHBOURS: coeff.neighbours <= cfg_data;
        REG_COEFF_SELF:       coeff.self_w     <= cfg_data;
        default: ;
      endcase
    end
  end

  pnt_sequencer u_sequencer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job       (job),
    .job_ready (job_ready),
    .status    (status)
  );

  pnt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .coeff     (coeff),
    .job       (job),
    .job_ready (job_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The closing results of a polygon must not be interleaved with new nodes.
  `PNT_ASSERT_NOW(a_no_input_in_tail, clk, rst, status.tail_busy, !in_ready, "input taken during polygon tail")

  // A valid final node always starts the two-result tail.
  `PNT_ASSERT_NEXT(a_tail_starts, clk, rst, in_valid && in_ready && in_data.last_node && status.node_count >= CNT_TWO && status.node_count < CNT_MAX, status.tail_busy, "tail not started after final node")

  // The first two nodes of a polygon produce no result.
  `PNT_ASSERT_NEXT(a_no_early_job, clk, rst, in_valid && in_ready && !in_data.last_node && status.node_count < CNT_TWO, !job.valid, "result issued for an opening node")

  // The error beat closes the polygon with zero coordinates.
  `PNT_ASSERT_NOW(a_bad_beat_form, clk, rst, out_valid && out_data.bad_polygon, out_data.last_result && out_data.new_x == '0 && out_data.new_y == '0, "malformed error beat")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for polygon_node_transform_core: closed polygons are streamed in,
// and every result beat is checked against a cycle-free predictor of the transform.
// Depends on pnt_pkg and the RTL of polygon_node_transform_core only.
module tb;
  import pnt_pkg::*;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fffffff;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h80000000;
  localparam logic [COEFF_W-1:0] COEFF_MAX = 24'h7fffff;
  localparam logic [COEFF_W-1:0] COEFF_MIN = 24'h800000;
  // Cycles allowed after the last owed result before the block is taken as idle. This
  // covers the three pipeline stages plus the two closing results of a final node.
  localparam int DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [COEFF_W-1:0]   cfg_data = '0;

  polygon_node_transform_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Node beats waiting to be sent, and result beats the block still owes us.
  in_beat_t  queued_nodes[$];
  out_beat_t pending_results[$];
  int        wrong_results = 0;

  // Burst idling on each side. A level of zero turns idling off; otherwise an idle
  // burst starts with a chance of one in (level + 1) per opportunity.
  int sender_idle = 0;
  int receiver_idle = 0;
  int send_gap = 0;
  int stall_left = 0;

  // Predictor state: the coefficients as sign-extended copies, the first two nodes of
  // the polygon for the wrap-around, the two most recent nodes and the node count.
  longint w_perp = $signed(COEFF_PERP_RESET);
  longint w_nbr  = $signed(COEFF_NEIGHBOURS_RESET);
  longint w_self = $signed(COEFF_SELF_RESET);
  node_t  poly_start = '0;
  node_t  poly_second = '0;
  node_t  prev2_node = '0;
  node_t  prev1_node = '0;
  int     nodes_seen = 0;

  // Rounds a Q27.32 sum to Q16.16 (half up, by flooring after adding one half) and
  // clamps it to the signed 32-bit range.
  function automatic logic [COORD_W-1:0] round_q16(longint acc);
    longint q;
    q = (acc + 64'sd32768) >>> 16;
    if (q > SAT_HI) q = SAT_HI;
    else if (q < SAT_LO) q = SAT_LO;
    return q[COORD_W-1:0];
  endfunction

  // Transformed node c with predecessor p and successor s. The perpendicular of
  // (s - p) is (dy, -dx), so x takes s.y - p.y and y takes p.x - s.x.
  function automatic out_beat_t transform_node(node_t p, node_t c, node_t s,
                                               int unsigned pos, logic closing);
    longint px, py, cx, cy, sx, sy;
    out_beat_t r;
    px = $signed(p.x);
    py = $signed(p.y);
    cx = $signed(c.x);
    cy = $signed(c.y);
    sx = $signed(s.x);
    sy = $signed(s.y);
    r.new_x = round_q16(w_perp * (sy - py) + w_nbr * (px + sx) + w_self * cx);
    r.new_y = round_q16(w_perp * (px - sx) + w_nbr * (py + sy) + w_self * cy);
    r.node_index = pos[IDX_W-1:0];
    r.last_result = closing;
    r.bad_polygon = 1'b0;
    return r;
  endfunction

  // Advances the predictor by one accepted node and books the results it starts.
  task automatic track_node(in_beat_t beat);
    node_t cur;
    node_t wrap_next;
    out_beat_t bad;
    cur.x = beat.node_x;
    cur.y = beat.node_y;
    if (beat.last_node) begin
      if (nodes_seen < 2 || nodes_seen >= MAX_NODES) begin
        // Too few or too many nodes: a single error beat closes the polygon.
        bad = '0;
        bad.last_result = 1'b1;
        bad.bad_polygon = 1'b1;
        pending_results.push_back(bad);
      end else begin
        // In a triangle the second node is still the most recent one kept.
        wrap_next = (nodes_seen == 2) ? prev1_node : poly_second;
        pending_results.push_back(transform_node(prev2_node, prev1_node, cur,
                                                 nodes_seen - 1, 1'b0));
        pending_results.push_back(transform_node(prev1_node, cur, poly_start,
                                                 nodes_seen, 1'b0));
        pending_results.push_back(transform_node(cur, poly_start, wrap_next, 0, 1'b1));
      end
      nodes_seen = 0;
    end else begin
      if (nodes_seen >= 2 && nodes_seen < MAX_NODES)
        pending_results.push_back(transform_node(prev2_node, prev1_node, cur,
                                                 nodes_seen - 1, 1'b0));
      if (nodes_seen == 0) poly_start = cur;
      else if (nodes_seen == 1) poly_second = cur;
      if (nodes_seen < MAX_NODES) nodes_seen++;
    end
    prev2_node = prev1_node;
    prev1_node = cur;
  endtask

  // Driver of the node channel. A new beat is put up only once the current one has
  // been taken, so valid and the payload hold steady while the block stalls.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (queued_nodes.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= queued_nodes.pop_front();
        if (sender_idle != 0 && $urandom_range(0, sender_idle) == 0)
          send_gap <= $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, again in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (receiver_idle != 0 && $urandom_range(0, receiver_idle) == 0)
        stall_left <= $urandom_range(1, 12);
    end
  end

  // Every node beat taken by the block feeds the predictor at the same edge.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) track_node(in_data);
  end

  // Every result beat is checked against the oldest owed result.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        wrong_results++;
        if (wrong_results <= 10)
          $display("%0t: unexpected result x=%h y=%h idx=%0d last=%b bad=%b", $time,
                   out_data.new_x, out_data.new_y, out_data.node_index,
                   out_data.last_result, out_data.bad_polygon);
      end else begin
        want = pending_results.pop_front();
        if (out_data.new_x !== want.new_x || out_data.new_y !== want.new_y ||
            out_data.node_index !== want.node_index ||
            out_data.last_result !== want.last_result ||
            out_data.bad_polygon !== want.bad_polygon) begin
          wrong_results++;
          if (wrong_results <= 10)
            $display("%0t: result mismatch, expected x=%h y=%h idx=%0d last=%b bad=%b",
                     $time, want.new_x, want.new_y, want.node_index, want.last_result,
                     want.bad_polygon, "; got x=%h y=%h idx=%0d last=%b bad=%b",
                     out_data.new_x, out_data.new_y, out_data.node_index,
                     out_data.last_result, out_data.bad_polygon);
        end
      end
    end
  end

  task automatic add_node(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
    in_beat_t beat;
    beat.node_x = x;
    beat.node_y = y;
    beat.last_node = last;
    queued_nodes.push_back(beat);
  endtask

  // Mostly small coordinates so that the weights matter, plus full-range words and
  // the two extremes so that every bit moves and saturation is hit.
  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 11))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3, 4: return $urandom();
      default: return $urandom_range(0, 32'h3fffff) - 32'h200000;
    endcase
  endfunction

  function automatic logic [COEFF_W-1:0] random_coeff();
    case ($urandom_range(0, 7))
      0:       return COEFF_MAX;
      1:       return COEFF_MIN;
      2:       return '0;
      3:       return COEFF_W'($urandom());
      default: return COEFF_W'($urandom_range(0, 24'h3ffff) - 24'h20000);
    endcase
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      2:       return 8;
      default: return 20;
    endcase
  endfunction

  task automatic queue_polygon(int count);
    for (int k = 0; k < count; k++)
      add_node(random_coord(), random_coord(), k == count - 1);
  endtask

  // Random polygons; about one in five is a short (one- or two-node) polygon.
  task automatic queue_random_polygons(int node_budget);
    int sent;
    int size;
    sent = 0;
    while (sent < node_budget) begin
      if ($urandom_range(0, 9) < 2) size = $urandom_range(1, 2);
      else size = $urandom_range(3, 12);
      queue_polygon(size);
      sent += size;
    end
  endtask

  // Four nodes at the corners of the coordinate range and around zero.
  task automatic queue_corner_polygon();
    add_node(COORD_MAX, COORD_MIN, 1'b0);
    add_node(COORD_MIN, COORD_MAX, 1'b0);
    add_node(32'h00000001, 32'hffffffff, 1'b0);
    add_node(32'hffffffff, 32'h00000001, 1'b1);
  endtask

  // Waits until every node is sent and every owed result has come back, then lets
  // the pipeline settle so that nothing is in flight at a coefficient write.
  task automatic wait_drained();
    while (queued_nodes.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three coefficients on consecutive edges and updates the predictor.
  task automatic load_coeffs(logic [COEFF_W-1:0] perp, logic [COEFF_W-1:0] nbr,
                             logic [COEFF_W-1:0] self_w);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_COEFF_PERP;
    cfg_data <= perp;
    @(posedge clk);
    cfg_index <= REG_COEFF_NEIGHBOURS;
    cfg_data <= nbr;
    @(posedge clk);
    cfg_index <= REG_COEFF_SELF;
    cfg_data <= self_w;
    @(posedge clk);
    cfg_write <= 1'b0;
    w_perp = $signed(perp);
    w_nbr = $signed(nbr);
    w_self = $signed(self_w);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset coefficients: short polygons of one and two
    // nodes, a triangle, the corner polygon and a pentagon whose products land on
    // exact halves so that rounding of both signs shows.
    sender_idle = 4;
    receiver_idle = 4;
    add_node(COORD_MAX, COORD_MIN, 1'b1);
    add_node(32'h00000005, 32'h00000007, 1'b0);
    add_node(32'hfffffffb, 32'hfffffff9, 1'b1);
    add_node(COORD_MAX, COORD_MAX, 1'b0);
    add_node(COORD_MIN, COORD_MIN, 1'b0);
    add_node(32'h00000000, 32'hffffffff, 1'b1);
    queue_corner_polygon();
    add_node(32'h00000001, 32'hffffffff, 1'b0);
    add_node(32'h00000003, 32'h00000005, 1'b0);
    add_node(32'hfffffff9, 32'h00000002, 1'b0);
    add_node(32'h00010000, 32'hffff0000, 1'b0);
    add_node(32'h00008000, 32'h7fff8000, 1'b1);
    wait_drained();

    // Both extremes of every coefficient drive the sums into saturation.
    load_coeffs(COEFF_MAX, COEFF_MAX, COEFF_MAX);
    queue_corner_polygon();
    wait_drained();
    load_coeffs(COEFF_MIN, COEFF_MIN, COEFF_MIN);
    queue_corner_polygon();
    wait_drained();

    // Random polygons under random coefficients and changing idle patterns.
    for (int phase = 0; phase < 5; phase++) begin
      load_coeffs(random_coeff(), random_coeff(), random_coeff());
      sender_idle = pick_idle();
      receiver_idle = pick_idle();
      queue_random_polygons(55);
      wait_drained();
    end

    // Closing part without idling: a last batch of random polygons back to back.
    sender_idle = 0;
    receiver_idle = 0;
    load_coeffs(random_coeff(), random_coeff(), random_coeff());
    queue_random_polygons(40);
    wait_drained();

    if (wrong_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pnt_pkg.sv
rtl/pnt_sequencer.sv
rtl/pnt_datapath.sv
rtl/polygon_node_transform_core.sv
tb/tb.sv
